[hw/rtl/bsc_pkg.sv]
// Package for the bright spot centroid block: sizes, register indexes,
// the frame job passed from the accumulator to the divider, and state codes.
// No dependencies.
`default_nettype none

package bsc_pkg;

  // Largest frame that the position counters and sums are sized for.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam longint MAX_PIXELS = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int COUNT_W = $clog2(MAX_PIXELS + 1);
  localparam int ROW_SUM_W = $clog2(longint'(MAX_HEIGHT - 1) * MAX_PIXELS + 1);
  localparam int COL_SUM_W = $clog2(longint'(MAX_WIDTH - 1) * MAX_PIXELS + 1);
  localparam int SUM_W   = (ROW_SUM_W > COL_SUM_W) ? ROW_SUM_W : COL_SUM_W;

  // Quotient width of the shared divider and its working width.
  localparam int QUO_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int DIV_W   = COUNT_W + QUO_W;
  localparam int STEP_W  = $clog2(QUO_W);

  // Colour byte and gray sum widths.
  localparam int BYTE_W     = 8;
  localparam int GRAY_SUM_W = BYTE_W + 2;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_SIZE_W  = 12;

  localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
  localparam logic [BYTE_W-1:0]     THRESHOLD_RESET    = 8'd200;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH      = 2'd0,
    CFG_FRAME_HEIGHT     = 2'd1,
    CFG_BRIGHT_THRESHOLD = 2'd2
  } cfg_index_t;

  // Settings as the accumulator uses them.
  typedef struct packed {
    logic [COL_W-1:0]      last_col;
    logic [ROW_W-1:0]      last_row;
    logic [GRAY_SUM_W-1:0] bright_limit;  // gray sum must exceed this
  } frame_cfg_t;

  // Totals of one finished frame.
  typedef struct packed {
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   col_sum;
    logic [COUNT_W-1:0] total;
  } frame_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROW,
    BK_COL,
    BK_SEND
  } bk_state_t;

endpackage

`default_nettype wire

[hw/rtl/bsc_if.sv]
// Channel interfaces of the bright spot centroid block: pixel input,
// centroid result and configuration write. Depends on bsc_pkg.
`default_nettype none

interface bsc_pix_if import bsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_start;
  logic [BYTE_W-1:0] blue_byte;
  logic [BYTE_W-1:0] green_byte;
  logic [BYTE_W-1:0] red_byte;

  modport source (output valid, frame_start, blue_byte, green_byte, red_byte,
                  input ready);
  modport sink   (input valid, frame_start, blue_byte, green_byte, red_byte,
                  output ready);
endinterface

interface bsc_res_if import bsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   centroid_row;
  logic [COL_W-1:0]   centroid_col;
  logic [COUNT_W-1:0] bright_count;
  logic               found;

  modport source (output valid, centroid_row, centroid_col, bright_count, found,
                  input ready);
  modport sink   (input valid, centroid_row, centroid_col, bright_count, found,
                  output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/bsc_front.sv]
// Pixel accumulator: tracks the raster position, thresholds each pixel and
// sums bright positions; hands a job to the queue at frame end. Uses bsc_pkg.
`default_nettype none

module bsc_front import bsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bsc_pix_if.sink         in_pix,
  input  wire frame_cfg_t cfg,
  input  wire logic       q_full,
  output logic            push,
  output frame_job_t      push_job
);

  logic [COL_W-1:0]   col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]   row_r, row_nxt, row_cur;
  logic [SUM_W-1:0]   row_sum_r, row_sum_nxt, row_sum_base;
  logic [SUM_W-1:0]   col_sum_r, col_sum_nxt, col_sum_base;
  logic [COUNT_W-1:0] total_r, total_nxt, total_base;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic bright, frame_end, accept;

  // A job can always be queued when a pixel is taken.
  assign in_pix.ready = !q_full;
  assign accept       = in_pix.valid && in_pix.ready;

  always_comb begin
    // A frame start drops whatever partial frame came before.
    col_cur      = in_pix.frame_start ? '0 : col_r;
    row_cur      = in_pix.frame_start ? '0 : row_r;
    row_sum_base = in_pix.frame_start ? '0 : row_sum_r;
    col_sum_base = in_pix.frame_start ? '0 : col_sum_r;
    total_base   = in_pix.frame_start ? '0 : total_r;

    gray_sum = GRAY_SUM_W'(in_pix.blue_byte) + GRAY_SUM_W'(in_pix.green_byte)
             + GRAY_SUM_W'(in_pix.red_byte);
    bright   = gray_sum > cfg.bright_limit;

    row_sum_nxt = row_sum_base + (bright ? SUM_W'(row_cur) : '0);
    col_sum_nxt = col_sum_base + (bright ? SUM_W'(col_cur) : '0);
    total_nxt   = total_base + (bright ? COUNT_W'(1) : '0);

    frame_end = (col_cur >= cfg.last_col) && (row_cur >= cfg.last_row);

    if (col_cur >= cfg.last_col) begin
      col_nxt = '0;
      row_nxt = row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end

    push              = accept && frame_end;
    push_job.row_sum  = row_sum_nxt;
    push_job.col_sum  = col_sum_nxt;
    push_job.total    = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      row_sum_r <= '0;
      col_sum_r <= '0;
      total_r   <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_r     <= '0;
        row_r     <= '0;
        row_sum_r <= '0;
        col_sum_r <= '0;
        total_r   <= '0;
      end else begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        row_sum_r <= row_sum_nxt;
        col_sum_r <= col_sum_nxt;
        total_r   <= total_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bsc_queue.sv]
// Short job queue between the pixel accumulator and the divider.
// Uses bsc_pkg for the job type and depth.
`default_nettype none

module bsc_queue import bsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_job_t push_job,
  output logic            full,
  input  wire logic       pop,
  output frame_job_t      pop_job,
  output logic            not_empty
);

  frame_job_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_job   = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    rptr_nxt  = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_nxt;
      if (pop)  rptr_r <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("job queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("job queue read while empty");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("job queue count overrun");

endmodule

`default_nettype wire

[hw/rtl/bsc_back.sv]
// Divider and result stage: takes frame jobs from the queue, divides both
// sums by the bright count with one shared restoring divider, and holds the
// result in an output register. Uses bsc_pkg.
`default_nettype none

module bsc_back import bsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire frame_job_t q_job,
  output logic            pop,
  bsc_res_if.source       out_res
);

  typedef struct packed {
    logic load_row;
    logic step;
    logic load_col;
    logic finish_col;
    logic send;
  } bk_ctrl_t;

  bk_state_t state_r, state_nxt;
  bk_ctrl_t  ctrl;

  logic [DIV_W-1:0]   rem_r, dsh_r, rem_step, dsh_init;
  logic [QUO_W-1:0]   q_r, q_step, row_q_r, col_q_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   col_sum_r;
  logic [COUNT_W-1:0] total_r;
  logic               ge, step_last, slot_free;

  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_found_r;

  assign slot_free = !out_valid_r || out_res.ready;
  assign step_last = step_r == STEP_W'(QUO_W - 1);

  // One quotient bit per cycle, most significant first.
  always_comb begin
    ge       = rem_r >= dsh_r;
    rem_step = ge ? rem_r - dsh_r : rem_r;
    q_step   = {q_r[QUO_W-2:0], ge};
    dsh_init = DIV_W'({total_r, {(QUO_W - 1){1'b0}}});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid)   state_nxt = BK_ROW;
      BK_ROW:  if (step_last) state_nxt = BK_COL;
      BK_COL:  if (step_last) state_nxt = BK_SEND;
      BK_SEND: if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      BK_IDLE: ctrl.load_row = q_valid;
      BK_ROW: begin
        ctrl.step     = !step_last;
        ctrl.load_col = step_last;
      end
      BK_COL: begin
        ctrl.step       = !step_last;
        ctrl.finish_col = step_last;
      end
      BK_SEND: ctrl.send = slot_free;
      default: ctrl = '0;
    endcase
  end

  assign pop = ctrl.load_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_row) begin
      rem_r     <= DIV_W'(q_job.row_sum);
      dsh_r     <= DIV_W'({q_job.total, {(QUO_W - 1){1'b0}}});
      col_sum_r <= q_job.col_sum;
      total_r   <= q_job.total;
      q_r       <= '0;
      step_r    <= '0;
    end else if (ctrl.load_col) begin
      row_q_r <= q_step;
      rem_r   <= DIV_W'(col_sum_r);
      dsh_r   <= dsh_init;
      q_r     <= '0;
      step_r  <= '0;
    end else if (ctrl.finish_col) begin
      col_q_r <= q_step;
    end else if (ctrl.step) begin
      rem_r  <= rem_step;
      dsh_r  <= dsh_r >> 1;
      q_r    <= q_step;
      step_r <= step_r + 1'b1;
    end
  end

  // Output register: a zero count forces the centroid to zero.
  always_ff @(posedge clk) begin
    if (ctrl.send) begin
      out_row_r   <= (total_r != '0) ? ROW_W'(row_q_r) : '0;
      out_col_r   <= (total_r != '0) ? COL_W'(col_q_r) : '0;
      out_count_r <= total_r;
      out_found_r <= total_r != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.send) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.centroid_row = out_row_r;
  assign out_res.centroid_col = out_col_r;
  assign out_res.bright_count = out_count_r;
  assign out_res.found        = out_found_r;

  a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r == (out_count_r != '0)))
    else $error("found flag disagrees with bright count");

  a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_row_r == '0 && out_col_r == '0))
    else $error("centroid not zero for frame without bright pixels");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == BK_ROW) else $error("job taken outside idle state");

  a_send_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.send |=> out_valid_r) else $error("result lost at output register");

endmodule

`default_nettype wire

[hw/rtl/bright_spot_centroid.sv]
// Top level of the bright spot centroid block: configuration registers,
// pixel accumulator, job queue and divider. Uses bsc_pkg, bsc_if, bsc_front,
// bsc_queue and bsc_back.
//
// Use: pixels arrive in raster order on in_pix, one per cycle at most; a set
// frame_start bit marks pixel (0,0) and drops any partial frame. A pixel is
// bright when the truncated mean of its three bytes exceeds the threshold.
// After the last pixel of a frame one result leaves on out_res: the truncated
// mean row and column of the bright pixels, their count and a found flag
// (centroid zero and found clear when no pixel was bright).
// Throughput: one pixel per cycle. The accumulator adds and compares each
// pixel in the cycle it is taken. At frame end the totals go into a two-entry
// queue; the divider then takes one quotient bit per cycle for the row and then
// for the column, and sends the result to the output register.
// in_pix.ready falls only when the queue holds two unfinished frames.
// Stalls: a result waits in the output register while out_res.ready is low;
// the divider can finish the next frame meanwhile, and the queue absorbs
// further frames before the pixel side is held.
// Reset (rst_n, synchronous) restores the register defaults of 640 by 480
// and threshold 200, clears positions, sums, queue and the output valid.
// cfg_wr is always ready; writes to an unused index are ignored.
`default_nettype none

module bright_spot_centroid import bsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bsc_cfg_if.sink   cfg_wr,
  bsc_pix_if.sink   in_pix,
  bsc_res_if.source out_res
);

  logic [CFG_SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [BYTE_W-1:0]     threshold_r;
  frame_cfg_t            frame_cfg;

  logic       q_full, q_push, q_pop, q_valid;
  frame_job_t push_job, pop_job;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
      threshold_r    <= THRESHOLD_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_FRAME_WIDTH:      frame_width_r  <= cfg_wr.data[CFG_SIZE_W-1:0];
        CFG_FRAME_HEIGHT:     frame_height_r <= cfg_wr.data[CFG_SIZE_W-1:0];
        CFG_BRIGHT_THRESHOLD: threshold_r    <= cfg_wr.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes are clamped to one up to the maximum, then turned into last
  // indices. A pixel is bright when the byte sum is at least 3*(t+1),
  // that is when it exceeds 3*t+2, so no division is needed.
  always_comb begin
    if (frame_width_r == '0) begin
      frame_cfg.last_col = '0;
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      frame_cfg.last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      frame_cfg.last_col = COL_W'(frame_width_r - 1'b1);
    end

    if (frame_height_r == '0) begin
      frame_cfg.last_row = '0;
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      frame_cfg.last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      frame_cfg.last_row = ROW_W'(frame_height_r - 1'b1);
    end

    frame_cfg.bright_limit = (GRAY_SUM_W'(threshold_r) << 1)
                           + GRAY_SUM_W'(threshold_r) + GRAY_SUM_W'(2);
  end

  bsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .cfg      (frame_cfg),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (push_job)
  );

  bsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  bsc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .pop     (q_pop),
    .out_res (out_res)
  );

  a_limit_tracks_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    frame_cfg.bright_limit == GRAY_SUM_W'(3) * GRAY_SUM_W'(threshold_r)
                              + GRAY_SUM_W'(2))
    else $error("bright limit out of step with threshold");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> q_full) else $error("pixel input held without full queue");

  a_last_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frame_cfg.last_col) < 32'(MAX_WIDTH)) else $error("last column beyond maximum");

endmodule

`default_nettype wire
